// ----- rtl/core/itag_pkg.sv -----
package itag_pkg;

  // Default sizes of the interval and track stores.
  localparam int unsigned MaxRecordsDef = 64;
  localparam int unsigned MaxTracksDef  = 16;

  // Fixed field widths of the request and result channels.
  localparam int unsigned TimeW = 31;
  localparam int unsigned RecW  = 6;
  localparam int unsigned TrkW  = 4;

  // Request operation codes.
  typedef enum logic {
    OpLoad = 1'b0,
    OpRun  = 1'b1
  } op_e;

endpackage

// ----- rtl/core/itag_if.sv -----
// Request channel: one interval load or one run command.
interface itag_req_if import itag_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [TimeW-1:0] start_time;
  logic [TimeW-1:0] stop_time;

  modport source (output valid, opcode, start_time, stop_time, input ready);
  modport sink   (input valid, opcode, start_time, stop_time, output ready);
endinterface

// Result channel: one placement per loaded interval.
interface itag_res_if import itag_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RecW-1:0] record_number;
  logic [TrkW-1:0] track_number;
  logic            opened_track;
  logic            track_overflow;
  logic            last_of_run;

  modport source (output valid, record_number, track_number, opened_track, track_overflow,
                  last_of_run, input ready);
  modport sink   (input valid, record_number, track_number, opened_track, track_overflow,
                  last_of_run, output ready);
endinterface

// ----- rtl/core/interval_track_assigner.sv -----
// Interval track assigner. Load requests store one interval each (begin and end) in order,
// up to MAX_RECORDS; further loads are dropped. A run request places every stored
// interval in order of rising begin (ties to the earliest loaded) on the best-fitting
// track, or opens a new one, and returns one result per interval, the final one
// flagged last_of_run; the stores are empty again afterwards, and a run with nothing
// loaded returns nothing. For each placement the minimum-begin search walks all loaded
// intervals, one entry a cycle through the single read port of the interval store, and
// the track store is then walked one track a cycle, over the tracks in use, by a shared
// subtract-and-compare unit; that walk is skipped while no track is open yet. The
// request channel is held off for the whole run; the final result may wait in its output
// register while new loads are taken.
module interval_track_assigner import itag_pkg::*; #(
  parameter int unsigned MAX_RECORDS = MaxRecordsDef,
  parameter int unsigned MAX_TRACKS  = MaxTracksDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  itag_req_if.sink   req_i,
  itag_res_if.source res_o
);

  localparam int unsigned RecIdxW = $clog2(MAX_RECORDS);
  localparam int unsigned RecCntW = $clog2(MAX_RECORDS + 1);
  localparam int unsigned TrkIdxW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int unsigned TrkCntW = $clog2(MAX_TRACKS + 1);

  localparam logic [RecCntW-1:0] RecMax = RecCntW'(MAX_RECORDS);
  localparam logic [TrkCntW-1:0] TrkMax = TrkCntW'(MAX_TRACKS);

  typedef enum logic [2:0] {
    StIdle,
    StPick,
    StPickEnd,
    StTrk,
    StTrkEnd,
    StPlace
  } state_e;

  state_e               state_q;
  logic [RecCntW-1:0]   loaded_q;
  logic [RecCntW-1:0]   done_q;
  logic [TrkCntW-1:0]   tracks_q;
  logic [MAX_RECORDS-1:0] placed_q;

  // Search over the interval store.
  logic [RecIdxW-1:0]   scan_q;
  logic                 cmp_vld_q;
  logic [RecIdxW-1:0]   cmp_idx_q;
  logic                 pick_found_q;
  logic [RecIdxW-1:0]   pick_idx_q;
  logic [TimeW-1:0]     pick_start_q;
  logic [TimeW-1:0]     pick_stop_q;

  // Search over the track store.
  logic [TrkIdxW-1:0]   tscan_q;
  logic                 tcmp_vld_q;
  logic [TrkIdxW-1:0]   tcmp_idx_q;
  logic                 trk_found_q;
  logic [TrkIdxW-1:0]   trk_idx_q;
  logic [TimeW-1:0]     gap_q;

  // Result register.
  logic                 out_vld_q;
  logic [RecW-1:0]      out_rec_q;
  logic [TrkW-1:0]      out_trk_q;
  logic                 out_open_q;
  logic                 out_ovf_q;
  logic                 out_last_q;

  // Memories and their registered read data.
  logic [TimeW-1:0]     start_mem [MAX_RECORDS];
  logic [TimeW-1:0]     stop_mem  [MAX_RECORDS];
  logic [TimeW-1:0]     trk_mem   [MAX_TRACKS];
  logic [TimeW-1:0]     start_rd_q;
  logic [TimeW-1:0]     stop_rd_q;
  logic [TimeW-1:0]     trk_rd_q;

  logic                 req_hs;
  logic                 load_we;
  logic                 pick_take;
  logic [TimeW:0]       diff;
  logic                 fits;
  logic                 trk_take;
  logic                 place_go;
  logic                 is_last;
  logic                 has_room;
  logic                 trk_we;
  logic [TrkIdxW-1:0]   trk_waddr;
  logic [TrkIdxW+TrkW-1:0] trk_wide;
  logic [RecIdxW+RecW-1:0] rec_wide;

  assign req_i.ready = (state_q == StIdle);
  assign req_hs      = req_i.valid && req_i.ready;
  assign load_we     = req_hs && (req_i.opcode == OpLoad) && (loaded_q < RecMax);

  // The begin compare keeps the first of equal begins.
  assign pick_take = cmp_vld_q && !placed_q[cmp_idx_q] &&
                     (!pick_found_q || (start_rd_q < pick_start_q));

  // Gap to a track; a negative difference means the track is still busy.
  assign diff     = {1'b0, pick_start_q} - {1'b0, trk_rd_q};
  assign fits     = !diff[TimeW];
  assign trk_take = tcmp_vld_q && fits && (!trk_found_q || (diff[TimeW-1:0] <= gap_q));

  // Placement happens once the result register is free.
  assign place_go  = (state_q == StPlace) && (!out_vld_q || res_o.ready);
  assign is_last   = ((done_q + RecCntW'(1)) == loaded_q);
  assign has_room  = (tracks_q < TrkMax);
  assign trk_waddr = trk_found_q ? trk_idx_q : tracks_q[TrkIdxW-1:0];
  assign trk_we    = place_go && (trk_found_q || has_room);
  assign trk_wide  = {{TrkW{1'b0}}, trk_waddr};
  assign rec_wide  = {{RecW{1'b0}}, pick_idx_q};

  // Interval store: written by loads, read one entry a cycle by the search.
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      start_mem[loaded_q[RecIdxW-1:0]] <= req_i.start_time;
      stop_mem[loaded_q[RecIdxW-1:0]]  <= req_i.stop_time;
    end
    start_rd_q <= start_mem[scan_q];
    stop_rd_q  <= stop_mem[scan_q];
  end

  // Track store: last end per track.
  always_ff @(posedge clk_i) begin
    if (trk_we) begin
      trk_mem[trk_waddr] <= pick_stop_q;
    end
    trk_rd_q <= trk_mem[tscan_q];
  end

  // Sequencer, search registers and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      loaded_q     <= '0;
      done_q       <= '0;
      tracks_q     <= '0;
      placed_q     <= '0;
      scan_q       <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      pick_found_q <= 1'b0;
      pick_idx_q   <= '0;
      pick_start_q <= '0;
      pick_stop_q  <= '0;
      tscan_q      <= '0;
      tcmp_vld_q   <= 1'b0;
      tcmp_idx_q   <= '0;
      trk_found_q  <= 1'b0;
      trk_idx_q    <= '0;
      gap_q        <= '0;
      out_vld_q    <= 1'b0;
      out_rec_q    <= '0;
      out_trk_q    <= '0;
      out_open_q   <= 1'b0;
      out_ovf_q    <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      cmp_vld_q  <= (state_q == StPick);
      cmp_idx_q  <= scan_q;
      tcmp_vld_q <= (state_q == StTrk);
      tcmp_idx_q <= tscan_q;

      // Running minimum of the begins.
      if (pick_take) begin
        pick_found_q <= 1'b1;
        pick_idx_q   <= cmp_idx_q;
        pick_start_q <= start_rd_q;
        pick_stop_q  <= stop_rd_q;
      end

      // Running best fit; equal gaps move to the later track.
      if (trk_take) begin
        trk_found_q <= 1'b1;
        trk_idx_q   <= tcmp_idx_q;
        gap_q       <= diff[TimeW-1:0];
      end

      // The taken result leaves the register unless a new one replaces it.
      if (res_o.ready && out_vld_q && !place_go) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (load_we) begin
            placed_q[loaded_q[RecIdxW-1:0]] <= 1'b0;
            loaded_q <= loaded_q + RecCntW'(1);
          end
          if (req_hs && (req_i.opcode == OpRun) && (loaded_q != '0)) begin
            scan_q       <= '0;
            done_q       <= '0;
            pick_found_q <= 1'b0;
            state_q      <= StPick;
          end
        end
        StPick: begin
          if ((RecCntW'(scan_q) + RecCntW'(1)) == loaded_q) begin
            state_q <= StPickEnd;
          end else begin
            scan_q <= scan_q + RecIdxW'(1);
          end
        end
        StPickEnd: begin
          tscan_q     <= '0;
          trk_found_q <= 1'b0;
          state_q     <= (tracks_q == '0) ? StPlace : StTrk;
        end
        StTrk: begin
          if ((TrkCntW'(tscan_q) + TrkCntW'(1)) == tracks_q) begin
            state_q <= StTrkEnd;
          end else begin
            tscan_q <= tscan_q + TrkIdxW'(1);
          end
        end
        StTrkEnd: begin
          state_q <= StPlace;
        end
        StPlace: begin
          if (place_go) begin
            out_vld_q  <= 1'b1;
            out_rec_q  <= rec_wide[RecW-1:0];
            out_last_q <= is_last;
            out_open_q <= !trk_found_q && has_room;
            out_ovf_q  <= !trk_found_q && !has_room;
            out_trk_q  <= (trk_found_q || has_room) ? trk_wide[TrkW-1:0] : '0;
            if (is_last) begin
              // Run complete: empty all stores.
              loaded_q <= '0;
              tracks_q <= '0;
              done_q   <= '0;
              placed_q <= '0;
              state_q  <= StIdle;
            end else begin
              if (!trk_found_q && has_room) begin
                tracks_q <= tracks_q + TrkCntW'(1);
              end
              placed_q[pick_idx_q] <= 1'b1;
              done_q       <= done_q + RecCntW'(1);
              scan_q       <= '0;
              pick_found_q <= 1'b0;
              state_q      <= StPick;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.record_number  = out_rec_q;
  assign res_o.track_number   = out_trk_q;
  assign res_o.opened_track   = out_open_q;
  assign res_o.track_overflow = out_ovf_q;
  assign res_o.last_of_run    = out_last_q;

endmodule

// ----- rtl/core/itag_checker.sv -----
// Port-level checks of the interval track assigner results.
module itag_checker import itag_pkg::*; #(
  parameter int unsigned MAX_TRACKS = MaxTracksDef
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            res_valid_i,
  input logic            res_ready_i,
  input logic [RecW-1:0] res_record_i,
  input logic [TrkW-1:0] res_track_i,
  input logic            res_opened_i,
  input logic            res_ovf_i,
  input logic            res_last_i
);

  localparam int unsigned OpenW = $clog2(MAX_TRACKS + 1);

  logic [OpenW-1:0]      opened_q;
  logic [OpenW+TrkW-1:0] opened_wide;

  assign opened_wide = {{TrkW{1'b0}}, opened_q};

  // Tracks opened so far in the current run, as seen on the result channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opened_q <= '0;
    end else if (res_valid_i && res_ready_i) begin
      if (res_last_i) begin
        opened_q <= '0;
      end else if (res_opened_i) begin
        opened_q <= opened_q + OpenW'(1);
      end
    end
  end

  // A stalled result keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_record_i) &&
    $stable(res_track_i) && $stable(res_opened_i) && $stable(res_ovf_i) && $stable(res_last_i))
    else $error("result changed while stalled");

  // New tracks are opened in index order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_opened_i |-> res_track_i == opened_wide[TrkW-1:0])
    else $error("opened track out of order");

  // Overflow only once every track is open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ovf_i |-> opened_q == OpenW'(MAX_TRACKS))
    else $error("overflow with tracks still free");

  // An unplaced interval carries no track.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ovf_i |-> !res_opened_i && res_track_i == '0)
    else $error("overflow result carries a track");

endmodule

bind interval_track_assigner itag_checker #(
  .MAX_TRACKS (MAX_TRACKS)
) u_itag_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_record_i (res_o.record_number),
  .res_track_i  (res_o.track_number),
  .res_opened_i (res_o.opened_track),
  .res_ovf_i    (res_o.track_overflow),
  .res_last_i   (res_o.last_of_run)
);
